@@ src/r2h_pkg.sv @@
// Shared widths and types for the RGB to HSL converter.
package r2h_pkg;

	localparam int ChanW  = 8;
	localparam int FracW  = 16;
	localparam int DivW   = 12;
	localparam int QuoW   = 17;
	localparam int LowW   = 17;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [FracW-1:0] frac_t;
	typedef logic [DivW-1:0]  div_t;
	typedef logic [QuoW-1:0]  quo_t;
	typedef logic [LowW-1:0]  low_t;

	typedef struct packed {
		frac_t lightness;
		frac_t saturation;
		frac_t hue;
	} hsl_t;

	typedef struct packed {
		logic  grey;
		frac_t lightness;
	} tag_t;

endpackage

@@ src/rgb_to_hsl_convert_top.sv @@
// RGB to HSL converter top level: sector select, lightness, two pipelined dividers, output skid.
// An accepted input beat passes stages 1 and 2, the divider stages and the output register to m_axis.
// Throughput: one beat per cycle while skid is empty; stages 1 and 2 feed two 17-stage dividers.
// Output register plus skid register; s_axis_tready drops only while the skid holds a beat.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module rgb_to_hsl_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // hue[15:0], saturation[31:16], lightness[47:32]
);

	localparam int Steps = r2h_pkg::QuoW;
	localparam logic [1:0] SEC_RED = 2'd0;
	localparam logic [1:0] SEC_GRN = 2'd1;
	localparam logic [1:0] SEC_BLU = 2'd2;

	logic en;
	logic skid_v_q;
	logic out_v_q;
	r2h_pkg::hsl_t skid_q;
	r2h_pkg::hsl_t out_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = !skid_v_q;

	// stage 1: max, min, sector
	r2h_pkg::chan_t in_r, in_g, in_b, mx, mn;
	logic [1:0] sec;

	assign in_r = s_axis_tdata[7:0];
	assign in_g = s_axis_tdata[15:8];
	assign in_b = s_axis_tdata[23:16];

	always_comb begin
		mx = in_r;
		mn = in_r;
		if (in_g > mx) mx = in_g;
		if (in_b > mx) mx = in_b;
		if (in_g < mn) mn = in_g;
		if (in_b < mn) mn = in_b;
		if (mx == in_r)
			sec = SEC_RED;
		else if (mx == in_g)
			sec = SEC_GRN;
		else
			sec = SEC_BLU;
	end

	logic           vld_s1;
	r2h_pkg::chan_t r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [1:0]     sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= in_r;
			g_s1   <= in_g;
			b_s1   <= in_b;
			mx_s1  <= mx;
			mn_s1  <= mn;
			sec_s1 <= sec;
		end
	end

	// stage 2: spread, divisor, hue numerator, lightness
	logic [7:0]  d;
	logic [8:0]  sum;
	logic [7:0]  sden;
	logic [10:0] d6, v, r11, g11, b11, d11;
	logic [17:0] lig_full;

	always_comb begin
		d   = mx_s1 - mn_s1;
		sum = {1'b0, mx_s1} + {1'b0, mn_s1};
		if (sum > 9'd255)
			sden = 8'(9'd510 - sum);
		else
			sden = sum[7:0];
		r11 = {3'b0, r_s1};
		g11 = {3'b0, g_s1};
		b11 = {3'b0, b_s1};
		d11 = {3'b0, d};
		d6  = (d11 << 2) + (d11 << 1);
		unique case (sec_s1)
			SEC_RED: v = (g_s1 >= b_s1) ? (g11 - b11) : (d6 - (b11 - g11));
			SEC_GRN: v = (b_s1 >= r_s1) ? ((d11 << 1) + (b11 - r11))
						: ((d11 << 1) - (r11 - b11));
			SEC_BLU: v = (r_s1 >= g_s1) ? ((d11 << 2) + (r11 - g11))
						: ((d11 << 2) - (g11 - r11));
			default: v = '0;
		endcase
		lig_full = {1'b0, sum, 8'b0} + {9'b0, sum} + 18'd1;
	end

	logic          vld_s2;
	logic [7:0]    d_s2;
	logic [7:0]    sden_s2;
	logic [10:0]   v_s2;
	r2h_pkg::tag_t tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2             <= d;
			sden_s2          <= sden;
			v_s2             <= v;
			tag_s2.grey      <= (d == 8'd0);
			tag_s2.lightness <= lig_full[16:1];
		end
	end

	// divider operands: hue = (v*2^17 + 6d) / 12d, sat = (d*131070 + den) / 2den
	logic [10:0]   hd6;
	logic [11:0]   hd12;
	logic [25:0]   snum;
	r2h_pkg::quo_t hue_q, sat_q;

	always_comb begin
		hd6  = ({3'b0, d_s2} << 2) + ({3'b0, d_s2} << 1);
		hd12 = {hd6, 1'b0};
		snum = 26'({18'b0, d_s2} * 26'd131070) + {18'b0, sden_s2};
	end

	r2h_div u_hue_div (
		.clk    (clk),
		.en     (en),
		.num_hi ({1'b0, v_s2}),
		.num_lo ({6'b0, hd6}),
		.den    (hd12),
		.quo    (hue_q)
	);

	r2h_div u_sat_div (
		.clk    (clk),
		.en     (en),
		.num_hi ({3'b0, snum[25:17]}),
		.num_lo (snum[16:0]),
		.den    ({3'b0, sden_s2, 1'b0}),
		.quo    (sat_q)
	);

	logic          vld_sd [Steps];
	r2h_pkg::tag_t tag_sd [Steps];

	for (genvar k = 0; k < Steps; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (en) begin
				vld_sd[k] <= (k == 0) ? vld_s2 : vld_sd[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_sd[k] <= (k == 0) ? tag_s2 : tag_sd[(k == 0) ? 0 : k-1];
			end
		end
	end

	// tail: assemble result
	r2h_pkg::hsl_t res;
	logic          tail_v;

	always_comb begin
		tail_v        = vld_sd[Steps-1];
		res.lightness = tag_sd[Steps-1].lightness;
		if (tag_sd[Steps-1].grey) begin
			res.hue        = '0;
			res.saturation = '0;
		end else begin
			res.hue        = hue_q[r2h_pkg::FracW-1:0];
			res.saturation = sat_q[r2h_pkg::QuoW-1] ? '1 : sat_q[r2h_pkg::FracW-1:0];
		end
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= tail_v;
			end
		end else if (tail_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule

@@ src/r2h_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with rounding numerator prepared outside.
module r2h_div (
	input  logic            clk,
	input  logic            en,
	input  r2h_pkg::div_t   num_hi,   // upper numerator bits, must be below den
	input  r2h_pkg::low_t   num_lo,   // lower numerator bits
	input  r2h_pkg::div_t   den,
	output r2h_pkg::quo_t   quo
);

	localparam int Steps = r2h_pkg::QuoW;

	r2h_pkg::div_t rem_sd [Steps];
	r2h_pkg::low_t low_sd [Steps];
	r2h_pkg::div_t den_sd [Steps];
	r2h_pkg::quo_t quo_sd [Steps];

	for (genvar k = 0; k < Steps; k++) begin : g_step
		r2h_pkg::div_t rem_in;
		r2h_pkg::low_t low_in;
		r2h_pkg::div_t den_in;
		r2h_pkg::quo_t quo_in;
		logic [r2h_pkg::DivW:0] trial;
		logic [r2h_pkg::DivW:0] diff;
		logic                   take;

		if (k == 0) begin : g_first
			assign rem_in = num_hi;
			assign low_in = num_lo;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[k-1];
			assign low_in = low_sd[k-1];
			assign den_in = den_sd[k-1];
			assign quo_in = quo_sd[k-1];
		end

		always_comb begin
			trial = {rem_in, low_in[r2h_pkg::LowW-1]};
			take  = trial >= {1'b0, den_in};
			diff  = trial - {1'b0, den_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= take ? diff[r2h_pkg::DivW-1:0] : trial[r2h_pkg::DivW-1:0];
				low_sd[k] <= {low_in[r2h_pkg::LowW-2:0], 1'b0};
				den_sd[k] <= den_in;
				quo_sd[k] <= {quo_in[r2h_pkg::QuoW-2:0], take};
			end
		end
	end

	assign quo = quo_sd[Steps-1];

endmodule

@@ dv/hsl_monitor.sv @@
// Pixel/HSL stream checker: predicts each result from the accepted pixel and compares in order.
module hsl_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	input  logic        pix_ready,
	input  logic [23:0] pix_data,   // red[7:0], green[15:8], blue[23:16]
	input  logic        hsl_valid,
	input  logic        hsl_ready,
	input  logic [47:0] hsl_data,   // hue[15:0], saturation[31:16], lightness[47:32]
	output int          errors,
	output int          pending
);

	r2h_pkg::hsl_t hsl_due [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// halves round up
	function automatic longint unsigned round_div(input longint unsigned num,
			input longint unsigned den);
		if (den == 0)
			return 0;
		return (num * 2 + den) / (den * 2);
	endfunction

	function automatic r2h_pkg::hsl_t rgb_to_hsl(input r2h_pkg::chan_t r,
			input r2h_pkg::chan_t g, input r2h_pkg::chan_t b);
		int unsigned     hi, lo, sum, d, den, ang;
		longint unsigned sat, lig;
		r2h_pkg::hsl_t   hsl;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = hi + lo;
		lig = round_div(sum * 65535, 510);
		hsl.lightness  = (lig > 65535) ? 16'hFFFF : lig[15:0];
		hsl.saturation = '0;
		hsl.hue        = '0;
		if (hi != lo) begin
			d   = hi - lo;
			den = (sum > 255) ? 510 - sum : sum;
			sat = round_div(d * 65535, den);
			hsl.saturation = (sat > 65535) ? 16'hFFFF : sat[15:0];
			// ties go to red, then green
			if (hi == r)
				ang = (g >= b) ? g - b : 6 * d - (b - g);
			else if (hi == g)
				ang = (b >= r) ? 2 * d + (b - r) : 2 * d - (r - b);
			else
				ang = (r >= g) ? 4 * d + (r - g) : 4 * d - (g - r);
			hsl.hue = 16'(round_div(longint'(ang) * 65536, 6 * d));
		end
		return hsl;
	endfunction

	task automatic check_field(input string name, input r2h_pkg::frac_t want,
			input r2h_pkg::frac_t got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		r2h_pkg::hsl_t want, got;
		if (arst_n) begin
			if (hsl_valid && hsl_ready) begin
				got = r2h_pkg::hsl_t'(hsl_data);
				if (hsl_due.size() == 0) begin
					errors++;
					$display("%0t: expected no beat got %h", $time, hsl_data);
				end else begin
					want = hsl_due.pop_front();
					check_field("hue", want.hue, got.hue);
					check_field("saturation", want.saturation, got.saturation);
					check_field("lightness", want.lightness, got.lightness);
				end
			end
			if (pix_valid && pix_ready)
				hsl_due.push_back(rgb_to_hsl(pix_data[7:0], pix_data[15:8], pix_data[23:16]));
			pending = hsl_due.size();
		end
	end

endmodule

@@ dv/tb.sv @@
// Testbench top for the RGB to HSL converter: clock, reset, pixel and result stream drivers.
module tb;

	localparam int StallLimit = 2000;
	localparam int NumRandom  = 1950;
	localparam int NumCorners = 22;

	typedef enum int {PixGrey, PixTieRG, PixTieGB, PixTieRB, PixRails, PixAny} pix_kind_e;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // hue[15:0], saturation[31:16], lightness[47:32]
	int          errors;
	int          pending;
	int          stalled = 0;

	rgb_to_hsl_convert_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hsl_monitor mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (s_axis_tvalid),
		.pix_ready (s_axis_tready),
		.pix_data  (s_axis_tdata),
		.hsl_valid (m_axis_tvalid),
		.hsl_ready (m_axis_tready),
		.hsl_data  (m_axis_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stalled <= 0;
		end else if (stalled >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	// result side: ready low a random count per beat; long after beat 500, none for 1100-1299
	initial begin : sink
		int  wait_cycles, beats;
		logic took;
		m_axis_tready = 1'b0;
		beats = 0;
		wait_cycles = $urandom_range(0, 7);
		forever begin
			@(posedge clk);
			took = m_axis_tvalid && m_axis_tready;
			@(negedge clk);
			if (took) begin
				beats++;
				if (beats == 500)
					wait_cycles = 300;   // long hold: fills the pipe, stalls the input
				else if (beats >= 1100 && beats < 1300)
					wait_cycles = 0;
				else
					wait_cycles = $urandom_range(0, 7);
			end
			if (arst_n && wait_cycles == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				if (arst_n) wait_cycles--;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic push_pixel(input r2h_pkg::chan_t r, input r2h_pkg::chan_t g,
			input r2h_pkg::chan_t b, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [23:0]    corners [NumCorners];
		r2h_pkg::chan_t r, g, b;
		pix_kind_e      kind;
		int             gap;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		// 0xRRGGBB
		corners = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hC8C832, 24'h0AC8C8, 24'hC80AC8,
			24'hFF0001, 24'h010000, 24'hFFFEFE, 24'hFFC864, 24'h643200, 24'hC83764,
			24'h808180, 24'h7F8080, 24'h000100, 24'hFE00FF};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NumCorners; i++)
			push_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0], $urandom_range(0, 7));

		for (int i = 0; i < NumRandom; i++) begin
			if (i == 1400) begin
				s_axis_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			r = r2h_pkg::chan_t'($urandom);
			g = r2h_pkg::chan_t'($urandom);
			b = r2h_pkg::chan_t'($urandom);
			kind = $urandom_range(0, 1) ? PixAny : pix_kind_e'($urandom_range(0, PixAny));
			case (kind)
				PixGrey: begin
					g = r;
					b = r;
				end
				PixTieRG: g = r;
				PixTieGB: b = g;
				PixTieRB: r = b;
				PixRails: begin
					r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					g = $urandom_range(0, 1) ? 8'hFF : g;
					b = $urandom_range(0, 1) ? 8'h00 : b;
				end
				default: ;
			endcase
			gap = (i >= 800 && i < 1000) ? 0 : $urandom_range(0, 7);
			push_pixel(r, g, b, gap);
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (30) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
src/r2h_pkg.sv
src/r2h_div.sv
src/rgb_to_hsl_convert_top.sv
dv/hsl_monitor.sv
dv/tb.sv
